// ===== rtl/core/srctok_pkg.sv =====
// srctok_pkg: shared types, token kind codes, character constants and
// character classification for the source tokenizer.
// No dependencies.
package srctok_pkg;

  // Default offset counter width
  localparam int OFFSET_BITS_DEF = 16;

  // Reported offset and length width (fixed by the result format)
  localparam int              RES_W   = 16;
  localparam logic [RES_W-1:0] RES_MAX = 16'hFFFF;

  // Result queue geometry
  localparam int Q_DEPTH = 4;
  localparam int PTR_W   = 2;
  localparam int CNT_W   = 3;

  // Lexer mode
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_IDENT = 3'd1,
    MODE_INT   = 3'd2,
    MODE_COLON = 3'd3,
    MODE_ERR   = 3'd4
  } mode_t;

  // Token kinds
  localparam logic [3:0] KIND_IDENT     = 4'd0;
  localparam logic [3:0] KIND_ASSIGN    = 4'd1;
  localparam logic [3:0] KIND_WHILE     = 4'd2;
  localparam logic [3:0] KIND_LT        = 4'd3;
  localparam logic [3:0] KIND_INT       = 4'd4;
  localparam logic [3:0] KIND_LBRACE    = 4'd5;
  localparam logic [3:0] KIND_RBRACE    = 4'd6;
  localparam logic [3:0] KIND_LPAREN    = 4'd7;
  localparam logic [3:0] KIND_RPAREN    = 4'd8;
  localparam logic [3:0] KIND_PLUS      = 4'd9;
  localparam logic [3:0] KIND_EOF       = 4'd10;
  localparam logic [3:0] KIND_BAD_COLON = 4'd11;
  localparam logic [3:0] KIND_BAD_CHAR  = 4'd12;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Keyword "while"
  localparam logic [2:0] KW_LEN = 3'd5;

  // One queued result
  typedef struct packed {
    logic [3:0]       kind;
    logic [RES_W-1:0] start;
    logic [RES_W-1:0] len;
    logic             last;
  } res_t;

  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h77; // w
      3'd1:    ch = 8'h68; // h
      3'd2:    ch = 8'h69; // i
      3'd3:    ch = 8'h6C; // l
      3'd4:    ch = 8'h65; // e
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_ident_start(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACE) ||
           (c == CH_RBRACE) || (c == CH_LT) || (c == CH_PLUS);
  endfunction

  function automatic logic [3:0] punct_kind(input logic [7:0] c);
    logic [3:0] k;
    priority case (c)
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_LT:     k = KIND_LT;
      default:   k = KIND_PLUS;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/core/source_tokenizer.sv =====
// source_tokenizer: streaming lexer, one source byte per item in, one token per item out.
// With an empty queue, the first token of a byte is offered the cycle after the byte is
// accepted; a second token from the same byte follows it in the queue.
// Throughput: one byte per cycle unless in_stall; a byte gives 0..2 tokens into a 4-entry
// queue, one token out per cycle unless out_stall; in_stall rises under two free slots.
// Reset (rst_n low, synchronous): mode idle, offsets and keyword match cleared, queue empty.
// Depends on srctok_pkg.
module source_tokenizer #(
  parameter int OFFSET_BITS = srctok_pkg::OFFSET_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // byte input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_byte_req,
  // token output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3:0]                    out_kind,
  output logic [srctok_pkg::RES_W-1:0]  out_start_res,
  output logic [srctok_pkg::RES_W-1:0]  out_length,
  output logic                          out_last_of_run
);
  import srctok_pkg::*;

  localparam int EXT_W = (OFFSET_BITS > RES_W) ? OFFSET_BITS : RES_W;

  // Clamp an offset to the reported width
  function automatic logic [RES_W-1:0] clamp_res(input logic [OFFSET_BITS-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    if (ext > EXT_W'(RES_MAX)) begin
      return RES_MAX;
    end
    return ext[RES_W-1:0];
  endfunction

  // Lexer state
  mode_t                  mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] tok_base_r, tok_base_nxt;
  logic [2:0]             kw_prog_r, kw_prog_nxt;
  logic                   kw_miss_r, kw_miss_nxt;

  // Result queue
  res_t                   q_r [Q_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;

  logic                   in_fire, out_fire;
  logic [7:0]             c;
  logic [OFFSET_BITS-1:0] pos_adv;
  logic [OFFSET_BITS-1:0] tok_len;
  logic                   cont_tok;   // byte extends the pending ident/int
  logic                   fresh_path; // byte is handled as a new token start
  logic                   kw_hit;

  logic                   flush_v, fresh_v;
  res_t                   flush_res, fresh_res;
  res_t                   push_a, push_b;
  logic [1:0]             push_n;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign c        = in_byte_req;

  assign pos_adv  = (pos_r == '1) ? pos_r : pos_r + OFFSET_BITS'(1);
  assign tok_len  = pos_r - tok_base_r;
  assign kw_hit   = !kw_miss_r && (kw_prog_r == KW_LEN);

  // Classify the byte against the current mode
  always_comb begin
    cont_tok   = 1'b0;
    fresh_path = 1'b0;
    unique case (mode_r)
      MODE_IDENT: begin
        cont_tok   = is_ident_start(c) || is_digit(c);
        fresh_path = !cont_tok;
      end
      MODE_INT: begin
        cont_tok   = is_digit(c);
        fresh_path = !cont_tok;
      end
      MODE_COLON, MODE_ERR: begin
        fresh_path = 1'b0;
      end
      default: begin
        fresh_path = 1'b1;
      end
    endcase
  end

  // Next state: mode, offsets, keyword match
  always_comb begin
    mode_nxt     = mode_r;
    pos_nxt      = pos_r;
    tok_base_nxt = tok_base_r;
    kw_prog_nxt  = kw_prog_r;
    kw_miss_nxt  = kw_miss_r;
    if (mode_r == MODE_ERR) begin
      if (c == CH_NUL) begin
        mode_nxt     = MODE_IDLE;
        pos_nxt      = '0;
        tok_base_nxt = '0;
        kw_prog_nxt  = '0;
        kw_miss_nxt  = 1'b0;
      end else begin
        pos_nxt = pos_adv;
      end
    end else if (mode_r == MODE_COLON) begin
      if (c == CH_EQUAL) begin
        mode_nxt = MODE_IDLE;
        pos_nxt  = pos_adv;
      end else if (c == CH_NUL) begin
        mode_nxt     = MODE_IDLE;
        pos_nxt      = '0;
        tok_base_nxt = '0;
        kw_prog_nxt  = '0;
        kw_miss_nxt  = 1'b0;
      end else begin
        mode_nxt = MODE_ERR;
        pos_nxt  = pos_adv;
      end
    end else if (cont_tok) begin
      pos_nxt = pos_adv;
      // keyword match only tracked for identifiers
      if (mode_r == MODE_IDENT && !kw_miss_r) begin
        if (kw_prog_r < KW_LEN && c == kw_char(kw_prog_r)) begin
          kw_prog_nxt = kw_prog_r + 3'd1;
        end else begin
          kw_miss_nxt = 1'b1;
        end
      end
    end else begin
      mode_nxt = MODE_IDLE;
      priority if (c == CH_NUL) begin
        pos_nxt      = '0;
        tok_base_nxt = '0;
        kw_prog_nxt  = '0;
        kw_miss_nxt  = 1'b0;
      end else if (is_space(c) || is_punct(c)) begin
        pos_nxt = pos_adv;
      end else if (c == CH_COLON) begin
        tok_base_nxt = pos_r;
        mode_nxt     = MODE_COLON;
        pos_nxt      = pos_adv;
      end else if (is_ident_start(c)) begin
        tok_base_nxt = pos_r;
        mode_nxt     = MODE_IDENT;
        pos_nxt      = pos_adv;
        kw_prog_nxt  = (c == kw_char(3'd0)) ? 3'd1 : 3'd0;
        kw_miss_nxt  = (c != kw_char(3'd0));
      end else if (is_digit(c)) begin
        tok_base_nxt = pos_r;
        mode_nxt     = MODE_INT;
        pos_nxt      = pos_adv;
      end else begin
        mode_nxt = MODE_ERR;
        pos_nxt  = pos_adv;
      end
    end
  end

  // Results: a pending token closed by this byte, then a token the byte starts itself
  always_comb begin
    flush_v   = 1'b0;
    flush_res = '{kind: KIND_IDENT, start: clamp_res(tok_base_r),
                  len: clamp_res(tok_len), last: 1'b0};
    fresh_v   = 1'b0;
    fresh_res = '{kind: KIND_EOF, start: clamp_res(pos_r), len: '0, last: 1'b1};
    if (mode_r == MODE_COLON) begin
      flush_v = 1'b1;
      if (c == CH_EQUAL) begin
        flush_res.kind = KIND_ASSIGN;
        flush_res.len  = RES_W'(2);
      end else begin
        flush_res.kind = KIND_BAD_COLON;
        flush_res.len  = RES_W'(1);
      end
    end else if (fresh_path && mode_r == MODE_IDENT) begin
      flush_v        = 1'b1;
      flush_res.kind = kw_hit ? KIND_WHILE : KIND_IDENT;
    end else if (fresh_path && mode_r == MODE_INT) begin
      flush_v        = 1'b1;
      flush_res.kind = KIND_INT;
    end
    if (fresh_path) begin
      priority if (c == CH_NUL) begin
        fresh_v = 1'b1;
      end else if (is_punct(c)) begin
        fresh_v        = 1'b1;
        fresh_res.kind = punct_kind(c);
        fresh_res.len  = RES_W'(1);
      end else if (!is_space(c) && c != CH_COLON && !is_ident_start(c) &&
                   !is_digit(c)) begin
        fresh_v        = 1'b1;
        fresh_res.kind = KIND_BAD_CHAR;
        fresh_res.len  = RES_W'(1);
      end else begin
        fresh_v = 1'b0;
      end
    end
    flush_res.last = !fresh_v;
  end

  // Queue write ordering
  always_comb begin
    push_a = flush_v ? flush_res : fresh_res;
    push_b = fresh_res;
    push_n = in_fire ? (2'(flush_v) + 2'(fresh_v)) : 2'd0;
  end

  assign cnt_nxt   = cnt_r + CNT_W'(push_n) - CNT_W'(out_fire);
  assign in_stall  = (cnt_r > CNT_W'(Q_DEPTH - 2));
  assign out_valid = (cnt_r != '0);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      pos_r      <= '0;
      tok_base_r <= '0;
      kw_prog_r  <= '0;
      kw_miss_r  <= 1'b0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
    end else begin
      if (in_fire) begin
        mode_r     <= mode_nxt;
        pos_r      <= pos_nxt;
        tok_base_r <= tok_base_nxt;
        kw_prog_r  <= kw_prog_nxt;
        kw_miss_r  <= kw_miss_nxt;
      end
      wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      rd_ptr_r <= rd_ptr_r + PTR_W'(out_fire);
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage, no reset
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= push_a;
    end
    if (push_n == 2'd2) begin
      q_r[wr_ptr_r + PTR_W'(1)] <= push_b;
    end
  end

  // Head of queue drives the output
  assign out_kind        = q_r[rd_ptr_r].kind;
  assign out_start_res   = q_r[rd_ptr_r].start;
  assign out_length      = q_r[rd_ptr_r].len;
  assign out_last_of_run = q_r[rd_ptr_r].last;

`ifndef SYNTHESIS
  // queue never overfills
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(Q_DEPTH))
    else $error("result queue overflow");

  // error mode drops bytes silently
  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && mode_r == MODE_ERR) |-> (push_n == 2'd0))
    else $error("token emitted in error mode");

  // two tokens only when a pending ident or int is closed
  a_two_src: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n == 2'd2) |-> (mode_r == MODE_IDENT || mode_r == MODE_INT))
    else $error("double result from wrong mode");

  // token start never lies past the current offset
  a_start_order: assert property (@(posedge clk) disable iff (!rst_n)
    tok_base_r <= pos_r)
    else $error("token start beyond position");

  // end of text always restarts the offset
  a_nul_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_byte_req == CH_NUL) |=> (pos_r == '0 && mode_r == MODE_IDLE))
    else $error("end of text did not restart");
`endif

endmodule

// ===== tb/source_tokenizer_checker.sv =====
// source_tokenizer_checker: watches the byte and token channels of the tokenizer,
// predicts every token from the accepted bytes and compares field by field.
// Depends on srctok_pkg for the token record, lexer modes, kinds and characters.
`timescale 1ns / 1ps

module source_tokenizer_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [7:0]                   in_byte_req,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [3:0]                   out_kind,
  input  logic [srctok_pkg::RES_W-1:0] out_start_res,
  input  logic [srctok_pkg::RES_W-1:0] out_length,
  input  logic                         out_last_of_run,
  output int unsigned                  mismatches,
  output int unsigned                  pending
);
  import srctok_pkg::*;

  localparam int POS_W = OFFSET_BITS_DEF;
  localparam logic [POS_W-1:0] POS_TOP = '1;
  localparam logic [39:0] KW_WORD = "while";

  // lexer state as the predictor sees it
  mode_t            lex_mode;
  logic [POS_W-1:0] lex_pos;
  logic [POS_W-1:0] tok_base;
  logic [2:0]       kw_seen;
  logic             kw_broken;

  res_t        expected_tokens[$];
  int unsigned err_count = 0;

  // character classes
  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_word_head(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == CH_UNDER;
  endfunction

  function automatic bit single_kind(input logic [7:0] c, output logic [3:0] k);
    k = KIND_PLUS;
    case (c)
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_LT:     k = KIND_LT;
      CH_PLUS:   k = KIND_PLUS;
      default:   return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // reported offsets and lengths clamp at the top of the result field
  function automatic logic [RES_W-1:0] sat_res(input logic [POS_W-1:0] v);
    longint unsigned w;
    w = 64'(v);
    return (w > 64'(RES_MAX)) ? RES_MAX : RES_W'(w);
  endfunction

  function automatic res_t make_tok(input logic [3:0] k, input logic [POS_W-1:0] s,
                                    input logic [POS_W-1:0] l);
    res_t t;
    t.kind  = k;
    t.start = sat_res(s);
    t.len   = sat_res(l);
    t.last  = 1'b0;
    return t;
  endfunction

  task automatic lex_restart();
    lex_mode  = MODE_IDLE;
    lex_pos   = '0;
    tok_base  = '0;
    kw_seen   = '0;
    kw_broken = 1'b0;
  endtask

  // position sticks at its top value
  task automatic bump_pos();
    if (lex_pos != POS_TOP) lex_pos = lex_pos + 1'b1;
  endtask

  task automatic feed_kw(input logic [7:0] c);
    int idx;
    if (kw_broken) return;
    idx = 39 - 8 * int'(kw_seen);
    if (kw_seen < KW_LEN && c == KW_WORD[idx -: 8]) kw_seen = kw_seen + 1'b1;
    else kw_broken = 1'b1;
  endtask

  // one source byte in, zero to two tokens out
  task automatic predict_byte(input logic [7:0] c);
    res_t       made[$];
    logic [3:0] pk;
    bit         done;
    done = 1'b0;
    case (lex_mode)
      MODE_ERR: begin
        if (c == CH_NUL) lex_restart();
        else bump_pos();
        done = 1'b1;
      end
      MODE_COLON: begin
        if (c == CH_EQUAL) begin
          made.push_back(make_tok(KIND_ASSIGN, tok_base, POS_W'(2)));
          lex_mode = MODE_IDLE;
          bump_pos();
        end else begin
          // the byte after a lone colon is swallowed; NUL still restarts
          made.push_back(make_tok(KIND_BAD_COLON, tok_base, POS_W'(1)));
          lex_mode = MODE_ERR;
          if (c == CH_NUL) lex_restart();
          else bump_pos();
        end
        done = 1'b1;
      end
      MODE_IDENT: begin
        if (is_word_head(c) || is_num(c)) begin
          feed_kw(c);
          bump_pos();
          done = 1'b1;
        end else begin
          made.push_back(make_tok((!kw_broken && kw_seen == KW_LEN) ? KIND_WHILE : KIND_IDENT,
                                  tok_base, lex_pos - tok_base));
          lex_mode = MODE_IDLE;
        end
      end
      MODE_INT: begin
        if (is_num(c)) begin
          bump_pos();
          done = 1'b1;
        end else begin
          made.push_back(make_tok(KIND_INT, tok_base, lex_pos - tok_base));
          lex_mode = MODE_IDLE;
        end
      end
      default: lex_mode = MODE_IDLE;
    endcase

    // the byte that ended a token is handled again as a fresh byte
    if (!done) begin
      if (c == CH_NUL) begin
        made.push_back(make_tok(KIND_EOF, lex_pos, '0));
        lex_restart();
      end else if (is_blank(c)) begin
        bump_pos();
      end else if (single_kind(c, pk)) begin
        made.push_back(make_tok(pk, lex_pos, POS_W'(1)));
        bump_pos();
      end else if (c == CH_COLON) begin
        tok_base = lex_pos;
        lex_mode = MODE_COLON;
        bump_pos();
      end else if (is_word_head(c)) begin
        tok_base  = lex_pos;
        kw_seen   = '0;
        kw_broken = 1'b0;
        feed_kw(c);
        lex_mode  = MODE_IDENT;
        bump_pos();
      end else if (is_num(c)) begin
        tok_base = lex_pos;
        lex_mode = MODE_INT;
        bump_pos();
      end else begin
        made.push_back(make_tok(KIND_BAD_CHAR, lex_pos, POS_W'(1)));
        lex_mode = MODE_ERR;
        bump_pos();
      end
    end

    if (made.size() > 0) made[made.size()-1].last = 1'b1;
    foreach (made[i]) expected_tokens.push_back(made[i]);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("source_tokenizer_tb: %s mismatch, got %0d expected %0d at %0t",
             what, got, want, $realtime);
    err_count++;
  endtask

  // tokens are checked before the byte of the same edge is predicted
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      lex_restart();
      expected_tokens.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch("unexpected token kind", out_kind, -1);
        end else begin
          want = expected_tokens.pop_front();
          if (out_kind !== want.kind) report_mismatch("kind", out_kind, want.kind);
          if (out_start_res !== want.start)
            report_mismatch("start", out_start_res, want.start);
          if (out_length !== want.len) report_mismatch("length", out_length, want.len);
          if (out_last_of_run !== want.last)
            report_mismatch("last_of_run", out_last_of_run, want.last);
        end
      end
      if (in_valid && !in_stall) predict_byte(in_byte_req);
    end
    mismatches <= err_count;
    pending    <= expected_tokens.size();
  end

endmodule

// ===== tb/source_tokenizer_tb.sv =====
// source_tokenizer_tb: drives source text into the tokenizer with random idling and
// stalls, and gives the verdict from the checker's mismatch and pending counts.
// Depends on srctok_pkg, source_tokenizer and source_tokenizer_checker.
`timescale 1ns / 1ps

module source_tokenizer_tb;
  import srctok_pkg::*;

  localparam int          RANDOM_ITEMS = 2000;
  localparam int          QUIET_FROM   = 1700;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  logic [7:0]       in_byte_req = 8'h00;
  logic             out_stall   = 1'b0;
  logic             in_stall;
  logic             out_valid;
  logic [3:0]       out_kind;
  logic [RES_W-1:0] out_start_res;
  logic [RES_W-1:0] out_length;
  logic             out_last_of_run;

  int unsigned mismatches;
  int unsigned pending_tokens;

  bit         send_idle_on = 1'b1;
  bit         recv_idle_on = 1'b1;
  bit         hold_req     = 1'b0;
  int         bytes_sent   = 0;
  logic [7:0] text_buf[$];

  source_tokenizer u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte_req    (in_byte_req),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_start_res  (out_start_res),
    .out_length     (out_length),
    .out_last_of_run(out_last_of_run)
  );

  source_tokenizer_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte_req    (in_byte_req),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_start_res  (out_start_res),
    .out_length     (out_length),
    .out_last_of_run(out_last_of_run),
    .mismatches     (mismatches),
    .pending        (pending_tokens)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // token receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (recv_idle_on && $urandom_range(0, 6) == 0) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(0, 10);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // one byte item, optionally after an idle burst
  task automatic send_byte(input logic [7:0] b);
    if (send_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_byte_req <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_byte(text_buf[i]);
    text_buf.delete();
  endtask

  // sender goes quiet until every predicted token has come out
  task automatic drain_tokens();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_tokens != 0) @(posedge clk);
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  function automatic logic [7:0] word_char(input bit head);
    int r;
    r = $urandom_range(0, head ? 52 : 62);
    if (r < 26) return 8'("A" + r);
    if (r < 52) return 8'("a" + r - 26);
    if (r == 52) return CH_UNDER;
    return 8'("0" + r - 53);
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // one well-formed token, or now and then a broken one
  task automatic add_piece();
    int sel;
    int n;
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      case ($urandom_range(0, 7))
        0:       add_str("while");
        1:       add_str("whil");
        2:       add_str("whiles");
        3:       add_str("While");
        4:       add_str("w");
        5:       add_str("whilewhile");
        6:       add_str("whi1e");
        default: add_str("_while");
      endcase
    end else if (sel < 30) begin
      n = $urandom_range(1, 10);
      text_buf.push_back(word_char(1'b1));
      repeat (n - 1) text_buf.push_back(word_char(1'b0));
    end else if (sel < 45) begin
      n = $urandom_range(1, 6);
      repeat (n) text_buf.push_back(8'("0" + $urandom_range(0, 9)));
    end else if (sel < 62) begin
      case ($urandom_range(0, 5))
        0:       text_buf.push_back(CH_LPAREN);
        1:       text_buf.push_back(CH_RPAREN);
        2:       text_buf.push_back(CH_LBRACE);
        3:       text_buf.push_back(CH_RBRACE);
        4:       text_buf.push_back(CH_LT);
        default: text_buf.push_back(CH_PLUS);
      endcase
    end else if (sel < 70) begin
      text_buf.push_back(CH_COLON);
      text_buf.push_back(CH_EQUAL);
    end else if (sel < 84) begin
      n = $urandom_range(1, 3);
      repeat (n) text_buf.push_back(blank_char());
    end else if (sel < 88) begin
      // lone colon followed by anything
      text_buf.push_back(CH_COLON);
      text_buf.push_back(8'($urandom_range(0, 255)));
    end else if (sel < 92) begin
      text_buf.push_back(8'($urandom_range(1, 255)));
    end else if (sel < 94) begin
      text_buf.push_back(CH_NUL);
    end else begin
      text_buf.push_back(word_char(1'b1));
    end
  endtask

  task automatic build_random_text();
    int n;
    text_buf.delete();
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(5, 30);
      repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(3, 30);
      repeat (n) begin
        add_piece();
        if ($urandom_range(0, 1) == 0) text_buf.push_back(blank_char());
      end
    end
    text_buf.push_back(CH_NUL);
  endtask

  // main stimulus and verdict
  initial begin
    int texts;
    int rand_base;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every kind, two tokens from one byte, lone colon, bad char, NUL in error
    add_str("while(");
    add_str("_Zz9)");
    add_str("09{}<+");
    add_str(":=");
    text_buf.push_back(CH_TAB);
    text_buf.push_back(CH_CR);
    text_buf.push_back(CH_LF);
    text_buf.push_back(CH_NUL);
    add_str(":x");
    text_buf.push_back(CH_NUL);
    text_buf.push_back(CH_COLON);
    text_buf.push_back(CH_NUL);
    text_buf.push_back(8'hFF);
    text_buf.push_back(CH_NUL);
    send_text();
    drain_tokens();

    // random texts
    texts     = 0;
    rand_base = bytes_sent;
    while (bytes_sent - rand_base < RANDOM_ITEMS) begin
      if (bytes_sent - rand_base >= QUIET_FROM) begin
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
      end else begin
        send_idle_on = ($urandom_range(0, 7) != 0);
        recv_idle_on = send_idle_on;
      end
      if (texts == 5) begin
        // long receiver hold while plus signs keep the result queue filling
        hold_req = 1'b1;
        text_buf.delete();
        repeat (30) text_buf.push_back(CH_PLUS);
        text_buf.push_back(CH_NUL);
      end else begin
        build_random_text();
      end
      send_text();
      if (texts == 12) drain_tokens();
      texts++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_tokens != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_tokens == 0) begin
      $display("source_tokenizer_tb: done, clean");
    end else begin
      $display("source_tokenizer_tb: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("source_tokenizer_tb: timeout after %0d cycles", cycle_cnt);
    $display("source_tokenizer_tb: done, errors");
    $finish;
  end

endmodule
